>>> sv/pft_pkg.sv
// Package for the point frame transform: widths, value types, register indexes and codes.
// Used by pft_wrap_lane and point_frame_transform; depends on nothing.
package pft_pkg;

    localparam int COORD_W   = 32;
    localparam int TRIG_W    = 18;
    localparam int TRIG_FRAC = 16;
    localparam int V_W       = 36;
    localparam int PROD_W    = COORD_W + TRIG_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic signed [V_W-1:0]     val_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef struct packed {
        val_t   v;
        logic   wrap;
        coord_t box;
    } lane_in_t;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLAGS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PKEY  = 3'd5;

    localparam int FLAG_MIRROR   = 0;
    localparam int FLAG_GLIDE    = 1;
    localparam int FLAG_SCREW    = 2;
    localparam int FLAG_RECENTER = 3;
    localparam int FLAG_WRAP     = 4;

    localparam logic [1:0] AXIS_NONE = 2'd3;
    localparam logic [1:0] SRC_ZERO  = 2'd3;

    localparam logic [1:0] PATH_PASS = 2'd0;
    localparam logic [1:0] PATH_ROT  = 2'd1;
    localparam logic [1:0] PATH_SHP  = 2'd2;
    localparam logic [1:0] PATH_SHN  = 2'd3;

    localparam logic KIND_HEADER = 1'b0;

    localparam int LANE_LAT = V_W + 2;

endpackage

>>> sv/pft_wrap_lane.sv
// One coordinate lane of the periodic wrap: floor modulo by the box through a pipelined
// restoring divider, one remainder bit per stage; without wrap, saturation instead. Depends on pft_pkg.
module pft_wrap_lane (
    input  logic              aclk,
    input  logic              en,
    input  pft_pkg::lane_in_t lane_in,
    output pft_pkg::coord_t   res
);
    import pft_pkg::*;

    logic [V_W-1:0]     mag_reg   [0:V_W];
    logic [COORD_W-1:0] rem_reg   [0:V_W];
    logic               neg_reg   [0:V_W];
    logic               wrap_reg  [0:V_W];
    coord_t             box_reg   [0:V_W];
    val_t               v_reg     [0:V_W];
    coord_t             res_reg;
    coord_t             res_next;
    logic [COORD_W-1:0] fix;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg[0]  <= lane_in.v[V_W-1] ? V_W'(-lane_in.v) : V_W'(lane_in.v);
            rem_reg[0]  <= '0;
            neg_reg[0]  <= lane_in.v[V_W-1];
            wrap_reg[0] <= lane_in.wrap;
            box_reg[0]  <= lane_in.box;
            v_reg[0]    <= lane_in.v;
        end
    end

    for (genvar k = 0; k < V_W; k++) begin : g_div
        logic [COORD_W:0] trial;
        logic [COORD_W:0] diff;
        always_comb begin
            trial = {rem_reg[k], mag_reg[k][V_W-1-k]};
            diff  = trial - {1'b0, box_reg[k]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= (trial >= {1'b0, box_reg[k]}) ? diff[COORD_W-1:0]
                                                               : trial[COORD_W-1:0];
                mag_reg[k+1]  <= mag_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                wrap_reg[k+1] <= wrap_reg[k];
                box_reg[k+1]  <= box_reg[k];
                v_reg[k+1]    <= v_reg[k];
            end
        end
    end

    always_comb begin
        fix = (neg_reg[V_W] && rem_reg[V_W] != '0) ? box_reg[V_W] - rem_reg[V_W]
                                                   : rem_reg[V_W];
        if (wrap_reg[V_W]) begin
            res_next = coord_t'(fix);
        end else if (v_reg[V_W] > val_t'({1'b0, {(COORD_W-1){1'b1}}})) begin
            res_next = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v_reg[V_W] < -val_t'({1'b0, {(COORD_W-1){1'b1}}}) - val_t'(1)) begin
            res_next = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res_next = coord_t'(v_reg[V_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> sv/point_frame_transform.sv
// Top level of the point frame transform: stream ports, configuration registers, frame state,
// five transform stages and three wrap lanes. Depends on pft_pkg and pft_wrap_lane.
//
// Usage: the slave stream carries one item per handshake; tuser is the request type
// (0 frame header, 1 point). A header holds box sizes in x/y/z and the frame's sine and
// cosine; it updates the frame state as it is accepted and yields the box as a result.
// A point yields the transformed coordinates. The master stream returns exactly one item
// per accepted item, in order, with tuser giving the kind.
// The pipeline has five transform stages, then 38 in each wrap lane (one setup
// stage, 36 divider stages of one remainder bit each, one output register).
// Throughput is one item per cycle. The whole pipeline advances together; when the
// master holds a result with tready low, every stage holds and s_tready falls.
// Configuration writes are always taken (cfg_ready is high) and must only happen while
// the block is empty. Reset clears all valid bits, the frame counter, box, center,
// sine and cosine, and loads the register defaults.
module point_frame_transform (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [135:0]                 s_tdata,  // in_x, in_y, in_z, sin_value, cos_value
    input  logic                         s_tuser,  // req_type
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [95:0]                  m_tdata,  // out_x, out_y, out_z
    output logic                         m_tuser,  // out_kind
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pft_pkg::CFG_DAT_W-1:0] cfg_data
);
    import pft_pkg::*;

    logic        adv;
    logic        acc;

    logic [1:0]  axis_reg;
    logic [1:0]  shear_reg;
    logic [4:0]  flags_reg;
    logic [15:0] first_reg;
    logic        pen_reg;
    logic [5:0]  pkey_reg;

    logic [31:0] frame_reg;
    coord_t      box_reg [0:2];
    coord_t      center_reg;
    trig_t       sin_reg;
    trig_t       cos_reg;

    coord_t      in_v [0:2];
    coord_t      pv   [0:2];
    logic        recenter;
    logic        is_hdr;

    always_comb begin
        adv       = !m_tvalid || m_tready;
        s_tready  = adv;
        acc       = s_tvalid && adv;
        cfg_ready = 1'b1;
        in_v[0]   = coord_t'(s_tdata[31:0]);
        in_v[1]   = coord_t'(s_tdata[63:32]);
        in_v[2]   = coord_t'(s_tdata[95:64]);
        for (int a = 0; a < 3; a++) begin
            if (!pen_reg) begin
                pv[a] = in_v[a];
            end else if (pkey_reg[2*a +: 2] == SRC_ZERO) begin
                pv[a] = '0;
            end else begin
                pv[a] = in_v[pkey_reg[2*a +: 2]];
            end
        end
        recenter = flags_reg[FLAG_RECENTER];
        is_hdr   = s_tuser == KIND_HEADER;
    end

    // Configuration and frame state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg   <= AXIS_NONE;
            shear_reg  <= '0;
            flags_reg  <= '0;
            first_reg  <= 16'd1;
            pen_reg    <= 1'b0;
            pkey_reg   <= '0;
            frame_reg  <= '0;
            box_reg[0] <= '0;
            box_reg[1] <= '0;
            box_reg[2] <= '0;
            center_reg <= '0;
            sin_reg    <= '0;
            cos_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_AXIS:  axis_reg  <= cfg_data[1:0];
                    REG_SHEAR: shear_reg <= cfg_data[1:0];
                    REG_FLAGS: flags_reg <= cfg_data[4:0];
                    REG_FIRST: first_reg <= cfg_data[15:0];
                    REG_PEN:   pen_reg   <= cfg_data[0];
                    REG_PKEY:  pkey_reg  <= cfg_data[5:0];
                    default: ;
                endcase
            end
            if (acc && is_hdr) begin
                frame_reg <= frame_reg + 32'd1;
                sin_reg   <= trig_t'(s_tdata[113:96]);
                cos_reg   <= trig_t'(s_tdata[131:114]);
                if (axis_reg != AXIS_NONE) begin
                    center_reg <= pv[axis_reg] >>> 1;
                end
                for (int a = 0; a < 3; a++) begin
                    box_reg[a] <= recenter ? '0 : pv[a];
                end
            end
        end
    end

    // Stage 0: capture the permuted item with a snapshot of the frame state.
    logic       s0_vld_reg;
    logic       s0_kind_reg;
    coord_t     s0_v_reg [0:2];
    logic [1:0] s0_ax_reg;
    logic       s0_act_reg;
    logic       s0_glide_reg;
    logic       s0_screw_reg;
    logic       s0_mirror_reg;
    logic       s0_rec_reg;
    logic [1:0] s0_shear_reg;
    trig_t      s0_sin_reg;
    trig_t      s0_cos_reg;
    coord_t     s0_c_reg;
    logic [2:0] s0_wrap_reg;
    coord_t     s0_box_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (adv) begin
            s0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_kind_reg   <= s_tuser;
            s0_ax_reg     <= (axis_reg == AXIS_NONE) ? 2'd0 : axis_reg;
            s0_act_reg    <= !is_hdr && axis_reg != AXIS_NONE
                             && frame_reg >= {16'd0, first_reg};
            s0_glide_reg  <= flags_reg[FLAG_GLIDE] && shear_reg == 2'd0;
            s0_screw_reg  <= flags_reg[FLAG_SCREW];
            s0_mirror_reg <= flags_reg[FLAG_MIRROR];
            s0_rec_reg    <= recenter;
            s0_shear_reg  <= shear_reg;
            s0_sin_reg    <= sin_reg;
            s0_cos_reg    <= cos_reg;
            s0_c_reg      <= center_reg;
            for (int a = 0; a < 3; a++) begin
                s0_v_reg[a]    <= is_hdr ? (recenter ? '0 : pv[a]) : pv[a];
                s0_wrap_reg[a] <= !is_hdr && axis_reg != AXIS_NONE
                                  && flags_reg[FLAG_WRAP] && box_reg[a] > 0;
                s0_box_reg[a]  <= box_reg[a];
            end
        end
    end

    // Stage 1: pick the rotation plane, center the axis, settle pass-through results.
    logic [1:0] ii;
    logic [1:0] jj;
    val_t       s1_pass_next [0:2];
    logic [1:0] s1_path_next;

    logic       s1_vld_reg;
    logic       s1_kind_reg;
    logic [1:0] s1_path_reg;
    logic [1:0] s1_ax_reg;
    logic [1:0] s1_i_reg;
    logic [1:0] s1_j_reg;
    coord_t     s1_vi_reg;
    coord_t     s1_vj_reg;
    val_t       s1_va_reg;
    logic       s1_mirror_reg;
    logic       s1_rec_reg;
    trig_t      s1_sin_reg;
    trig_t      s1_cos_reg;
    coord_t     s1_c_reg;
    val_t       s1_pass_reg [0:2];
    logic [2:0] s1_wrap_reg;
    coord_t     s1_box_reg [0:2];

    always_comb begin
        ii = (s0_ax_reg == 2'd2) ? 2'd0 : s0_ax_reg + 2'd1;
        jj = (ii == 2'd2) ? 2'd0 : ii + 2'd1;
        for (int a = 0; a < 3; a++) begin
            if (s0_act_reg && s0_glide_reg && s0_ax_reg == 2'(a)) begin
                s1_pass_next[a] = val_t'(s0_c_reg) - val_t'(s0_v_reg[a]);
            end else begin
                s1_pass_next[a] = val_t'(s0_v_reg[a]);
            end
        end
        if (!s0_act_reg || s0_glide_reg) begin
            s1_path_next = PATH_PASS;
        end else if (s0_shear_reg == 2'd0) begin
            s1_path_next = PATH_ROT;
        end else if (!s0_shear_reg[1]) begin
            s1_path_next = PATH_SHP;
        end else begin
            s1_path_next = PATH_SHN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_kind_reg   <= s0_kind_reg;
            s1_path_reg   <= s1_path_next;
            s1_ax_reg     <= s0_ax_reg;
            s1_i_reg      <= ii;
            s1_j_reg      <= jj;
            s1_vi_reg     <= s0_v_reg[ii];
            s1_vj_reg     <= s0_v_reg[jj];
            s1_va_reg     <= val_t'(s0_v_reg[s0_ax_reg])
                             - (s0_screw_reg ? val_t'(0) : val_t'(s0_c_reg));
            s1_mirror_reg <= s0_mirror_reg;
            s1_rec_reg    <= s0_rec_reg;
            s1_sin_reg    <= s0_sin_reg;
            s1_cos_reg    <= s0_cos_reg;
            s1_c_reg      <= s0_c_reg;
            s1_wrap_reg   <= s0_wrap_reg;
            for (int a = 0; a < 3; a++) begin
                s1_pass_reg[a] <= s1_pass_next[a];
                s1_box_reg[a]  <= s0_box_reg[a];
            end
        end
    end

    // Stage 2: the four trig products.
    logic       s2_vld_reg;
    logic       s2_kind_reg;
    logic [1:0] s2_path_reg;
    logic [1:0] s2_ax_reg;
    logic [1:0] s2_i_reg;
    logic [1:0] s2_j_reg;
    coord_t     s2_vi_reg;
    coord_t     s2_vj_reg;
    val_t       s2_va_reg;
    logic       s2_mirror_reg;
    logic       s2_rec_reg;
    coord_t     s2_c_reg;
    prod_t      s2_pci_reg;
    prod_t      s2_psj_reg;
    prod_t      s2_psi_reg;
    prod_t      s2_pcj_reg;
    val_t       s2_pass_reg [0:2];
    logic [2:0] s2_wrap_reg;
    coord_t     s2_box_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (adv) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_kind_reg   <= s1_kind_reg;
            s2_path_reg   <= s1_path_reg;
            s2_ax_reg     <= s1_ax_reg;
            s2_i_reg      <= s1_i_reg;
            s2_j_reg      <= s1_j_reg;
            s2_vi_reg     <= s1_vi_reg;
            s2_vj_reg     <= s1_vj_reg;
            s2_va_reg     <= s1_va_reg;
            s2_mirror_reg <= s1_mirror_reg;
            s2_rec_reg    <= s1_rec_reg;
            s2_c_reg      <= s1_c_reg;
            s2_pci_reg    <= prod_t'(s1_cos_reg) * prod_t'(s1_vi_reg);
            s2_psj_reg    <= prod_t'(s1_sin_reg) * prod_t'(s1_vj_reg);
            s2_psi_reg    <= prod_t'(s1_sin_reg) * prod_t'(s1_vi_reg);
            s2_pcj_reg    <= prod_t'(s1_cos_reg) * prod_t'(s1_vj_reg);
            s2_wrap_reg   <= s1_wrap_reg;
            for (int a = 0; a < 3; a++) begin
                s2_pass_reg[a] <= s1_pass_reg[a];
                s2_box_reg[a]  <= s1_box_reg[a];
            end
        end
    end

    // Stage 3: sums with rounding to nearest, half up; mirror on the axis.
    localparam sum_t HALF = sum_t'(1) <<< (TRIG_FRAC - 1);

    sum_t       sum_i;
    sum_t       sum_j;
    val_t       s3_ni_next;
    val_t       s3_nj_next;

    logic       s3_vld_reg;
    logic       s3_kind_reg;
    logic       s3_pass_sel_reg;
    logic [1:0] s3_ax_reg;
    logic [1:0] s3_i_reg;
    logic [1:0] s3_j_reg;
    val_t       s3_ni_reg;
    val_t       s3_nj_reg;
    val_t       s3_na_reg;
    logic       s3_rec_reg;
    coord_t     s3_c_reg;
    val_t       s3_pass_reg [0:2];
    logic [2:0] s3_wrap_reg;
    coord_t     s3_box_reg [0:2];

    always_comb begin
        sum_i      = '0;
        sum_j      = '0;
        s3_ni_next = val_t'(s2_vi_reg);
        s3_nj_next = val_t'(s2_vj_reg);
        unique case (s2_path_reg)
            PATH_ROT: begin
                sum_i      = sum_t'(s2_pci_reg) - sum_t'(s2_psj_reg) + HALF;
                sum_j      = sum_t'(s2_psi_reg) + sum_t'(s2_pcj_reg) + HALF;
                s3_ni_next = val_t'(sum_i >>> TRIG_FRAC);
                s3_nj_next = val_t'(sum_j >>> TRIG_FRAC);
            end
            PATH_SHP: begin
                sum_j      = sum_t'(s2_psi_reg) + HALF;
                s3_nj_next = val_t'(s2_vj_reg) + val_t'(sum_j >>> TRIG_FRAC);
            end
            PATH_SHN: begin
                sum_i      = sum_t'(s2_psj_reg) + HALF;
                s3_ni_next = val_t'(s2_vi_reg) + val_t'(sum_i >>> TRIG_FRAC);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (adv) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_kind_reg     <= s2_kind_reg;
            s3_pass_sel_reg <= s2_path_reg == PATH_PASS;
            s3_ax_reg       <= s2_ax_reg;
            s3_i_reg        <= s2_i_reg;
            s3_j_reg        <= s2_j_reg;
            s3_ni_reg       <= s3_ni_next;
            s3_nj_reg       <= s3_nj_next;
            s3_na_reg       <= s2_mirror_reg ? -s2_va_reg : s2_va_reg;
            s3_rec_reg      <= s2_rec_reg;
            s3_c_reg        <= s2_c_reg;
            s3_wrap_reg     <= s2_wrap_reg;
            for (int a = 0; a < 3; a++) begin
                s3_pass_reg[a] <= s2_pass_reg[a];
                s3_box_reg[a]  <= s2_box_reg[a];
            end
        end
    end

    // Stage 4: add the center back unless recentering, and map the plane onto x, y, z.
    lane_in_t   s4_lane_next [0:2];
    lane_in_t   s4_lane_reg  [0:2];
    logic       s4_vld_reg;
    logic       s4_kind_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            s4_lane_next[a].wrap = s3_wrap_reg[a];
            s4_lane_next[a].box  = s3_box_reg[a];
            if (s3_pass_sel_reg) begin
                s4_lane_next[a].v = s3_pass_reg[a];
            end else if (s3_ax_reg == 2'(a)) begin
                s4_lane_next[a].v = s3_na_reg
                                    + (s3_rec_reg ? val_t'(0) : val_t'(s3_c_reg));
            end else if (s3_i_reg == 2'(a)) begin
                s4_lane_next[a].v = s3_ni_reg;
            end else begin
                s4_lane_next[a].v = s3_nj_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (adv) begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_kind_reg <= s3_kind_reg;
            for (int a = 0; a < 3; a++) begin
                s4_lane_reg[a] <= s4_lane_next[a];
            end
        end
    end

    // Wrap lanes, with valid and kind traveling alongside.
    coord_t lane_res [0:2];
    logic   lv_reg [0:LANE_LAT-1];
    logic   lk_reg [0:LANE_LAT-1];

    for (genvar a = 0; a < 3; a++) begin : g_lane
        pft_wrap_lane u_lane (
            .aclk    (aclk),
            .en      (adv),
            .lane_in (s4_lane_reg[a]),
            .res     (lane_res[a])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                lv_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            lv_reg[0] <= s4_vld_reg;
            for (int k = 1; k < LANE_LAT; k++) begin
                lv_reg[k] <= lv_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lk_reg[0] <= s4_kind_reg;
            for (int k = 1; k < LANE_LAT; k++) begin
                lk_reg[k] <= lk_reg[k-1];
            end
        end
    end

    assign m_tvalid = lv_reg[LANE_LAT-1];
    assign m_tuser  = lk_reg[LANE_LAT-1];
    assign m_tdata  = {lane_res[2], lane_res[1], lane_res[0]};

    // A header advances the frame count by one; a point leaves it alone.
    a_hdr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == KIND_HEADER
        |=> frame_reg == $past(frame_reg) + 32'd1)
        else $error("frame count did not advance on a header");

    a_pt_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != KIND_HEADER
        |=> frame_reg == $past(frame_reg))
        else $error("frame count changed on a point");

    // With recentering, a header leaves the stored box at zero.
    a_rec_box: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == KIND_HEADER && flags_reg[FLAG_RECENTER]
        |=> box_reg[0] == '0 && box_reg[1] == '0 && box_reg[2] == '0)
        else $error("box not cleared by a recentering header");

    // A stall freezes the whole pipeline, stage 0 included.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(s0_vld_reg) && $stable(s4_vld_reg))
        else $error("pipeline moved during a stall");

endmodule

>>> tb/sv/pft_checker.sv
// Checker for the point frame transform: watches the configuration and stream channels,
// predicts each result item from its own copy of the frame state and compares in order.
// Depends on pft_pkg.
`timescale 1ns / 100ps

module pft_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [135:0]                  s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [95:0]                   m_tdata,
    input  logic                          m_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [pft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pft_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                            fail_count,
    output int                            pending_count
);
    import pft_pkg::*;

    typedef struct packed {
        logic   kind;
        coord_t x;
        coord_t y;
        coord_t z;
    } coord_item_t;

    coord_item_t  expected_q[$];
    logic [1:0]   axis_r;
    logic signed [1:0] shear_r;
    logic [4:0]   flags_r;
    logic [15:0]  first_r;
    logic         pen_r;
    logic [5:0]   pkey_r;
    logic [31:0]  frame_cnt;
    longint       box_r[3];
    longint       center_r;
    longint       sin_r;
    longint       cos_r;

    assign pending_count = expected_q.size();

    function automatic longint round_trig(longint p);
        return (p + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return coord_t'(v);
    endfunction

    // Updates the frame state on a header and returns the predicted result item.
    function automatic coord_item_t transform_item(logic is_point, logic [135:0] d);
        longint v[3];
        longint src[4];
        longint c[3];
        longint ni, nj, md;
        int ax, i, j;
        coord_item_t r;
        src[0] = longint'(signed'(d[31:0]));
        src[1] = longint'(signed'(d[63:32]));
        src[2] = longint'(signed'(d[95:64]));
        src[3] = 0;
        for (int a = 0; a < 3; a++)
            v[a] = pen_r ? src[pkey_r[2*a +: 2]] : src[a];
        if (!is_point) begin
            sin_r = longint'(signed'(d[113:96]));
            cos_r = longint'(signed'(d[131:114]));
            frame_cnt = frame_cnt + 1;
            if (axis_r != AXIS_NONE) center_r = v[axis_r] >>> 1;
            for (int a = 0; a < 3; a++) box_r[a] = flags_r[FLAG_RECENTER] ? 0 : v[a];
            r.kind = KIND_HEADER;
            r.x = coord_t'(box_r[0]);
            r.y = coord_t'(box_r[1]);
            r.z = coord_t'(box_r[2]);
            return r;
        end
        if (axis_r != AXIS_NONE) begin
            ax = axis_r;
            i = (ax + 1) % 3;
            j = (i + 1) % 3;
            c[0] = 0; c[1] = 0; c[2] = 0;
            c[ax] = center_r;
            if (frame_cnt >= {16'd0, first_r}) begin
                if (shear_r == 0 && flags_r[FLAG_GLIDE]) begin
                    for (int a = 0; a < 3; a++)
                        v[a] = (a == ax) ? c[a] - v[a] : v[a] + c[a];
                end else begin
                    if (!flags_r[FLAG_SCREW]) v[ax] -= c[ax];
                    if (shear_r > 0) begin
                        v[j] += round_trig(sin_r * v[i]);
                    end else if (shear_r < 0) begin
                        v[i] += round_trig(sin_r * v[j]);
                    end else begin
                        ni = round_trig(cos_r * v[i] - sin_r * v[j]);
                        nj = round_trig(sin_r * v[i] + cos_r * v[j]);
                        v[i] = ni;
                        v[j] = nj;
                    end
                    if (flags_r[FLAG_MIRROR]) v[ax] = -v[ax];
                    if (!flags_r[FLAG_RECENTER]) v[ax] += c[ax];
                end
            end
            if (flags_r[FLAG_WRAP]) begin
                for (int a = 0; a < 3; a++) begin
                    if (box_r[a] > 0) begin
                        md = v[a] % box_r[a];
                        if (md < 0) md += box_r[a];
                        v[a] = md;
                    end
                end
            end
        end
        r.kind = 1'b1;
        r.x = clamp_coord(v[0]);
        r.y = clamp_coord(v[1]);
        r.z = clamp_coord(v[2]);
        return r;
    endfunction

    always @(posedge aclk) begin
        coord_item_t got;
        coord_item_t want;
        if (!aresetn) begin
            axis_r <= AXIS_NONE;
            shear_r <= 2'sd0;
            flags_r <= 5'd0;
            first_r <= 16'd1;
            pen_r <= 1'b0;
            pkey_r <= 6'd0;
            frame_cnt <= 0;
            box_r <= '{0, 0, 0};
            center_r <= 0;
            sin_r <= 0;
            cos_r <= 0;
            expected_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_AXIS: axis_r <= cfg_data[1:0];
                    REG_SHEAR: shear_r <= cfg_data[1:0];
                    REG_FLAGS: flags_r <= cfg_data[4:0];
                    REG_FIRST: first_r <= cfg_data;
                    REG_PEN: pen_r <= cfg_data[0];
                    REG_PKEY: pkey_r <= cfg_data[5:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(transform_item(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]};
                if (expected_q.size() == 0) begin
                    $error("unexpected result item %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        fail_count <= fail_count + 1;
                        if (got.kind != want.kind)
                            $error("out_kind expected %0d actual %0d", want.kind, got.kind);
                        if (got.x != want.x)
                            $error("out_x expected %0d actual %0d", want.x, got.x);
                        if (got.y != want.y)
                            $error("out_y expected %0d actual %0d", want.y, got.y);
                        if (got.z != want.z)
                            $error("out_z expected %0d actual %0d", want.z, got.z);
                    end
                end
            end
        end
    end

endmodule

>>> tb/sv/tb_point_frame_transform.sv
// Testbench top for point_frame_transform: clock, reset, register phases, directed and
// random frames of points with random idling. Depends on pft_pkg, pft_checker and the block.
`timescale 1ns / 100ps

module tb_point_frame_transform;
    import pft_pkg::*;

    localparam int  DRAIN_CYCLES = 60;
    localparam longint CYCLE_LIMIT = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    int           fail_count;
    int           pending_count;
    longint       cycle_count = 0;
    logic         sink_stall_on = 1'b1;

    always #4 aclk = ~aclk;

    point_frame_transform u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    pft_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending_count(pending_count)
    );

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_point_frame_transform failed");
            $finish;
        end
    end

    // Result side stalls at random, with quiet stretches where it is always ready.
    initial begin
        int g;
        forever begin
            @(negedge aclk);
            g = sink_stall_on ? gap_length() : 0;
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic is_point, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [17:0] s, input logic [17:0] c,
                             input logic allow_gap);
        int g;
        g = allow_gap ? gap_length() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tdata <= {4'd0, c, s, z, y, x};
        s_tuser <= is_point;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [17:0] rand_trig();
        case ($urandom_range(0, 5))
            0: return 18'h10000;
            1: return 18'h30000;
            2: return 18'h00000;
            default: return 18'($urandom_range(0, 131072) - 65536);
        endcase
    endfunction

    function automatic logic [31:0] rand_coord(input logic [31:0] box_hint);
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            3: return -($urandom_range(0, 32'h00ffffff));
            default: return $urandom_range(0, box_hint == 0 ? 32'h00ffffff : box_hint);
        endcase
    endfunction

    function automatic logic [31:0] rand_box();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return -($urandom_range(1, 32'h00100000));
            2: return 32'h7fffffff;
            3: return $urandom();
            default: return $urandom_range(1, 32'h01000000);
        endcase
    endfunction

    task automatic random_config(input logic edge_values);
        write_reg(REG_AXIS, edge_values ? 16'd0 : 16'($urandom_range(0, 3)));
        write_reg(REG_SHEAR, 16'($urandom_range(0, 3)));
        write_reg(REG_FLAGS, edge_values ? 16'd31 : 16'($urandom_range(0, 31)));
        write_reg(REG_FIRST, edge_values ? 16'hffff : 16'($urandom_range(0, 3)));
        write_reg(REG_PEN, 16'($urandom_range(0, 1)));
        write_reg(REG_PKEY, 16'($urandom_range(0, 63)));
    endtask

    initial begin
        int sent;
        int npts;
        logic [31:0] bx;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Points before any header, then headers and points at the field extremes.
        send_item(1'b1, 32'h7fffffff, 32'h80000000, 32'h00010000, 18'h0, 18'h0, 1'b1);
        drain_block();
        write_reg(REG_AXIS, 16'd2);
        write_reg(REG_FIRST, 16'd0);
        send_item(1'b1, 32'h00030000, 32'hfffd0000, 32'h00050001, 18'h0, 18'h0, 1'b1);
        send_item(1'b0, 32'h00100000, 32'h00200000, 32'h00300001, 18'h10000, 18'h30000, 1'b1);
        send_item(1'b1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 18'h0, 18'h0, 1'b0);
        send_item(1'b1, 32'h80000000, 32'h7fffffff, 32'h80000000, 18'h0, 18'h0, 1'b0);
        send_item(1'b0, 32'hffffffff, 32'h80000000, 32'h7fffffff, 18'h30000, 18'h10000, 1'b0);
        send_item(1'b1, 32'h12345678, 32'h87654321, 32'hffff0000, 18'h0, 18'h0, 1'b1);
        drain_block();
        write_reg(REG_SHEAR, 16'd1);
        write_reg(REG_FLAGS, 16'd31);
        write_reg(REG_PEN, 16'd1);
        write_reg(REG_PKEY, 16'd63);
        send_item(1'b0, 32'h00100000, 32'h00200000, 32'h00300000, 18'h08000, 18'h0ddb3, 1'b0);
        send_item(1'b1, 32'h00050000, 32'h00060000, 32'h00070000, 18'h0, 18'h0, 1'b0);
        drain_block();
        write_reg(REG_SHEAR, 16'd3);
        write_reg(REG_FLAGS, 16'd17);
        write_reg(REG_PKEY, 16'd36);
        send_item(1'b0, 32'h00100000, 32'h00200000, 32'h00300000, 18'h08000, 18'h0ddb3, 1'b0);
        send_item(1'b1, 32'hfffb0000, 32'h00460000, 32'h00070000, 18'h0, 18'h0, 1'b0);
        send_item(1'b1, 32'h7fffffff, 32'h80000000, 32'h00000001, 18'h0, 18'h0, 1'b0);
        drain_block();

        // Random phases: a header followed by a run of points, under changing settings.
        sent = 0;
        while (sent < 1500) begin
            random_config(sent == 0 || $urandom_range(0, 9) == 0);
            sink_stall_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 6)) begin
                bx = rand_box();
                send_item(1'b0, bx, rand_box(), rand_box(), rand_trig(), rand_trig(), 1'b1);
                npts = $urandom_range(1, 30);
                repeat (npts) begin
                    send_item(1'b1, rand_coord(bx), rand_coord(bx), rand_coord(bx),
                              18'($urandom()), 18'($urandom()), 1'b1);
                end
                sent += npts + 1;
            end
            drain_block();
        end

        sink_stall_on = 1'b1;
        drain_block();
        if (fail_count == 0) begin
            $display("tb_point_frame_transform passed");
        end else begin
            $display("tb_point_frame_transform failed");
        end
        $finish;
    end

endmodule

>>> point_frame_transform.f
sv/pft_pkg.sv
sv/pft_wrap_lane.sv
sv/point_frame_transform.sv
tb/sv/pft_checker.sv
tb/sv/tb_point_frame_transform.sv
